// ===== rtl/core/wsf_pkg.sv =====
// shared constants, codes and item types of the window statistics block
`timescale 1ns / 1ps

package wsf_pkg;

   localparam int MAX_SAMPLES = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
   localparam int CNT_BITS    = $clog2(MAX_SAMPLES + 1);

   localparam int FRAC_BITS   = 16;
   localparam int VALUE_BITS  = 48;
   localparam int INDEX_BITS  = 4;
   localparam int MINCNT_BITS = 6;

   // running sums and the n*Q - S*S term
   localparam int SUM_BITS   = SAMPLE_BITS + CNT_BITS;
   localparam int SUMSQ_BITS = 2 * SAMPLE_BITS + CNT_BITS;
   localparam int DEV_BITS   = SUMSQ_BITS + CNT_BITS;

   // shared divider and root unit
   localparam int DIV_BITS  = DEV_BITS + 2 * FRAC_BITS;
   localparam int DEN_BITS  = VALUE_BITS;
   localparam int ROOT_BITS = DIV_BITS / 2;

   localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

   localparam logic [MINCNT_BITS-1:0] MIN_COUNT_RESET = MINCNT_BITS'(8);
   localparam logic [MINCNT_BITS-1:0] MIN_COUNT_FLOOR = MINCNT_BITS'(2);

   // normalized deviation clamp
   localparam int ZQ_BITS = 25;
   localparam logic [ZQ_BITS-1:0] Z_LIM = {1'b1, {(ZQ_BITS-1){1'b0}}};

   localparam logic [1:0] PEARSON_GAIN = 2'd3;

   // feature codes in emission order
   localparam logic [INDEX_BITS-1:0] FEAT_SD       = 4'd0;
   localparam logic [INDEX_BITS-1:0] FEAT_VAR      = 4'd1;
   localparam logic [INDEX_BITS-1:0] FEAT_RMS      = 4'd2;
   localparam logic [INDEX_BITS-1:0] FEAT_MSQ      = 4'd3;
   localparam logic [INDEX_BITS-1:0] FEAT_PEARSON  = 4'd4;
   localparam logic [INDEX_BITS-1:0] FEAT_KURTOSIS = 4'd5;
   localparam logic [INDEX_BITS-1:0] FEAT_SKEWNESS = 4'd6;
   localparam logic [INDEX_BITS-1:0] FEAT_MIN      = 4'd7;
   localparam logic [INDEX_BITS-1:0] FEAT_MAX      = 4'd8;
   localparam logic [INDEX_BITS-1:0] FEAT_MEAN     = 4'd9;
   localparam logic [INDEX_BITS-1:0] FEAT_MEDIAN   = 4'd10;
   localparam logic [INDEX_BITS-1:0] FEAT_MAD      = 4'd11;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   window_end;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]        feature_index;
      logic signed [VALUE_BITS-1:0] feature_value;
      logic                         too_few;
      logic                         final_result;
   } rsp_type;

endpackage

// ===== rtl/core/window_statistics_features.sv =====
// window statistics block: sample store, shared divider and root, feature sequencer
// intake: one sample a cycle while loading; after the closing item the sequencer runs
//   the feature pass before the first of twelve items (a short window gives one
//   too-few item instead); no item is taken during the pass, which is set by the
//   bit-serial divider and the two rank selections, each sweeping the single-read
//   sample memory once per candidate
// reset: synchronous, active high; clears the sequencer, sample count, output valid
//   and min_count (back to 8); the sample memory itself is not cleared
`timescale 1ns / 1ps

module window_statistics_features
   import wsf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [MINCNT_BITS-1:0] csr_wr_data
);

   // sequencer codes
   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_PREP1     = 5'd1;
   localparam logic [4:0] ST_PREP2     = 5'd2;
   localparam logic [4:0] ST_SD_DIV    = 5'd3;
   localparam logic [4:0] ST_SD_SQRT   = 5'd4;
   localparam logic [4:0] ST_RMS_DIV   = 5'd5;
   localparam logic [4:0] ST_RMS_SQRT  = 5'd6;
   localparam logic [4:0] ST_MEAN_DIV  = 5'd7;
   localparam logic [4:0] ST_SEL_RD    = 5'd8;
   localparam logic [4:0] ST_SEL_CAP   = 5'd9;
   localparam logic [4:0] ST_SEL_SCAN  = 5'd10;
   localparam logic [4:0] ST_PEAR_DIV  = 5'd11;
   localparam logic [4:0] ST_Z_RD      = 5'd12;
   localparam logic [4:0] ST_Z_CAP     = 5'd13;
   localparam logic [4:0] ST_Z_DIV     = 5'd14;
   localparam logic [4:0] ST_Z_SQ      = 5'd15;
   localparam logic [4:0] ST_Z_POW     = 5'd16;
   localparam logic [4:0] ST_Z_ACC     = 5'd17;
   localparam logic [4:0] ST_KURT_GO   = 5'd18;
   localparam logic [4:0] ST_KURT_DIV  = 5'd19;
   localparam logic [4:0] ST_SKEW_DIV  = 5'd20;
   localparam logic [4:0] ST_EMIT      = 5'd21;
   localparam logic [4:0] ST_ERR       = 5'd22;

   // widths of the normalized moment path
   localparam int MEAN_BITS  = SAMPLE_BITS + FRAC_BITS;
   localparam int PD_BITS    = MEAN_BITS + 2;
   localparam int Z2_BITS    = 2 * ZQ_BITS - FRAC_BITS;
   localparam int Z4_BITS    = 2 * Z2_BITS - FRAC_BITS;
   localparam int Z3_BITS    = Z2_BITS + ZQ_BITS - FRAC_BITS;
   localparam int Z4SUM_BITS = Z4_BITS + CNT_BITS;
   localparam int Z3SUM_BITS = Z3_BITS + CNT_BITS + 1;

   // sequencer and counters
   logic [4:0]             state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_nx, n_ff, idx_ff, j_ff, lt_ff, le_ff;
   logic [CNT_BITS-1:0]    k_sel, thr;
   logic                   dv_ff, sel_mad_ff, found;
   logic [INDEX_BITS-1:0]  emit_idx_ff;
   logic                   emit_load;
   logic [MINCNT_BITS-1:0] min_count_ff;

   logic                   req_acc, store_wr, too_short;

   // sample memory, one write and one registered read a cycle
   logic [SAMPLE_BITS-1:0] store_ff [MAX_SAMPLES];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]   rd_addr;

   // running window sums and extremes
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SUMSQ_BITS-1:0]  sumsq_ff;
   logic [SAMPLE_BITS-1:0] min_ff, max_ff, med_ff, mad_ff, cand_ff;

   logic [2*CNT_BITS-1:0]  nm1_ff;
   logic [DEV_BITS-1:0]    nq_ff, ss_ff;

   // shared bit-serial divider
   logic                   div_run_ff, div_load;
   logic [DIV_BITS-1:0]    div_num_ff, div_q_ff, div_num_ld;
   logic [DEN_BITS-1:0]    div_den_ff, div_den_ld, div_rem_ff, div_rem_nx;
   logic [DEN_BITS:0]      div_rem_sh;
   logic                   div_ge;
   logic [6:0]             div_cnt_ff;

   // shared two-bits-a-step square root
   logic                   sq_run_ff, sq_load;
   logic [DIV_BITS-1:0]    sq_rad_ff, sq_rad_ld;
   logic [ROOT_BITS+1:0]   sq_rem_ff, sq_rem_nx;
   logic [ROOT_BITS+3:0]   sq_r2, sq_trial;
   logic [ROOT_BITS-1:0]   sq_root_ff;
   logic                   sq_ge;
   logic [5:0]             sq_cnt_ff;

   // feature results
   logic [VALUE_BITS-1:0]  sd_ff, var_ff, rms_ff, msq_ff, mean_ff;
   logic [VALUE_BITS-1:0]  pear_ff, kurt_ff, skew_ff, feat_val;
   logic                   pneg_ff, zneg_ff;

   // moment path
   logic signed [PD_BITS-1:0] pear_diff, z_diff;
   logic [PD_BITS-1:0]     pear_mag, z_mag;
   logic [PD_BITS+1:0]     pear_mag3;
   logic [ZQ_BITS-1:0]     az_ff;
   logic [Z2_BITS-1:0]     z2_ff;
   logic [Z4_BITS-1:0]     z4_ff;
   logic [Z3_BITS-1:0]     z3_ff;
   logic [2*ZQ_BITS-1:0]   z2_prod;
   logic [2*Z2_BITS-1:0]   z4_prod;
   logic [Z2_BITS+ZQ_BITS-1:0] z3_prod;
   logic [Z4SUM_BITS-1:0]  z4sum_ff;
   logic signed [Z3SUM_BITS-1:0] zs3_ff;
   logic [Z3SUM_BITS-1:0]  zs3_mag;
   logic [VALUE_BITS-1:0]  skew_mag;

   // output register
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   // quotient clipped to the largest positive value
   function automatic logic [VALUE_BITS-1:0] sat_q(input logic [DIV_BITS-1:0] q);
      if (q > DIV_BITS'(VAL_MAX)) begin
         return VAL_MAX;
      end
      return q[VALUE_BITS-1:0];
   endfunction

   // value ranked by the selection sweep: the sample, or its distance to the median
   function automatic logic [SAMPLE_BITS-1:0] sel_val(
      input logic [SAMPLE_BITS-1:0] x,
      input logic [SAMPLE_BITS-1:0] med,
      input logic                   mad_mode
   );
      if (!mad_mode) begin
         return x;
      end
      return (x >= med) ? x - med : med - x;
   endfunction

   // ---------------------------------------------------------------------------
   // handshake and sample counting
   // ---------------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   // samples past the store depth are dropped, the count holds
   assign store_wr  = req_acc && (cnt_ff != CNT_BITS'(MAX_SAMPLES));
   assign cnt_nx    = store_wr ? cnt_ff + CNT_BITS'(1) : cnt_ff;
   // a threshold below two still needs two samples
   assign thr       = (min_count_ff < MIN_COUNT_FLOOR) ? CNT_BITS'(MIN_COUNT_FLOOR)
                                                       : CNT_BITS'(min_count_ff);
   assign too_short = (cnt_nx < thr);

   // rank wanted by median and deviation selection
   assign k_sel = n_ff >> 1;
   assign found = (lt_ff <= k_sel) && (k_sel < le_ff);

   // ---------------------------------------------------------------------------
   // signed numerators for pearson skew and per-sample deviation
   // ---------------------------------------------------------------------------
   assign pear_diff = $signed({2'b00, mean_ff[MEAN_BITS-1:0]})
                    - $signed({2'b00, med_ff, {FRAC_BITS{1'b0}}});
   assign pear_mag  = pear_diff[PD_BITS-1] ? PD_BITS'(-pear_diff) : PD_BITS'(pear_diff);
   assign pear_mag3 = (PD_BITS+2)'(pear_mag) * (PD_BITS+2)'(PEARSON_GAIN);

   assign z_diff = $signed({2'b00, rd_data_ff, {FRAC_BITS{1'b0}}})
                 - $signed({2'b00, mean_ff[MEAN_BITS-1:0]});
   assign z_mag  = z_diff[PD_BITS-1] ? PD_BITS'(-z_diff) : PD_BITS'(z_diff);

   assign z2_prod = (2*ZQ_BITS)'(az_ff) * (2*ZQ_BITS)'(az_ff);
   assign z4_prod = (2*Z2_BITS)'(z2_ff) * (2*Z2_BITS)'(z2_ff);
   assign z3_prod = (Z2_BITS+ZQ_BITS)'(z2_ff) * (Z2_BITS+ZQ_BITS)'(az_ff);

   assign zs3_mag  = zs3_ff[Z3SUM_BITS-1] ? Z3SUM_BITS'(-zs3_ff) : Z3SUM_BITS'(zs3_ff);
   assign skew_mag = div_q_ff[VALUE_BITS-1:0];

   // ---------------------------------------------------------------------------
   // divider step: restoring, one quotient bit a cycle
   // ---------------------------------------------------------------------------
   assign div_rem_sh = {div_rem_ff, div_num_ff[DIV_BITS-1]};
   assign div_ge     = (div_rem_sh >= {1'b0, div_den_ff});
   assign div_rem_nx = div_ge ? DEN_BITS'(div_rem_sh - {1'b0, div_den_ff})
                              : DEN_BITS'(div_rem_sh);

   // root step: two radicand bits a cycle, floor result
   assign sq_r2     = {sq_rem_ff, sq_rad_ff[DIV_BITS-1 -: 2]};
   assign sq_trial  = {2'b00, sq_root_ff, 2'b01};
   assign sq_ge     = (sq_r2 >= sq_trial);
   assign sq_rem_nx = sq_ge ? (ROOT_BITS+2)'(sq_r2 - sq_trial) : (ROOT_BITS+2)'(sq_r2);

   // ---------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      div_load   = 1'b0;
      div_num_ld = '0;
      div_den_ld = '0;
      sq_load    = 1'b0;
      sq_rad_ld  = '0;
      emit_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.window_end) begin
               state_in = too_short ? ST_ERR : ST_PREP1;
            end
         end
         ST_PREP1: begin
            state_in = ST_PREP2;
         end
         ST_PREP2: begin
            // variance numerator n*Q - S*S, scaled for the root
            div_load   = 1'b1;
            div_num_ld = DIV_BITS'({nq_ff - ss_ff, {(2*FRAC_BITS){1'b0}}});
            div_den_ld = DEN_BITS'(nm1_ff);
            state_in   = ST_SD_DIV;
         end
         ST_SD_DIV: begin
            if (!div_run_ff) begin
               sq_load    = 1'b1;
               sq_rad_ld  = div_q_ff;
               div_load   = 1'b1;
               div_num_ld = DIV_BITS'({sumsq_ff, {(2*FRAC_BITS){1'b0}}});
               div_den_ld = DEN_BITS'(n_ff);
               state_in   = ST_SD_SQRT;
            end
         end
         ST_SD_SQRT: begin
            if (!sq_run_ff) begin
               state_in = ST_RMS_DIV;
            end
         end
         ST_RMS_DIV: begin
            if (!div_run_ff) begin
               sq_load    = 1'b1;
               sq_rad_ld  = div_q_ff;
               div_load   = 1'b1;
               div_num_ld = DIV_BITS'({sum_ff, {FRAC_BITS{1'b0}}});
               div_den_ld = DEN_BITS'(n_ff);
               state_in   = ST_RMS_SQRT;
            end
         end
         ST_RMS_SQRT: begin
            if (!sq_run_ff) begin
               state_in = ST_MEAN_DIV;
            end
         end
         ST_MEAN_DIV: begin
            if (!div_run_ff) begin
               state_in = ST_SEL_RD;
            end
         end
         ST_SEL_RD: begin
            state_in = ST_SEL_CAP;
         end
         ST_SEL_CAP: begin
            state_in = ST_SEL_SCAN;
         end
         ST_SEL_SCAN: begin
            if ((j_ff == n_ff) && !dv_ff) begin
               if (!found) begin
                  state_in = ST_SEL_RD;
               end else if (!sel_mad_ff) begin
                  state_in = ST_SEL_RD;
               end else if (sd_ff == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  div_load   = 1'b1;
                  div_num_ld = DIV_BITS'({pear_mag3, {FRAC_BITS{1'b0}}});
                  div_den_ld = sd_ff;
                  state_in   = ST_PEAR_DIV;
               end
            end
         end
         ST_PEAR_DIV: begin
            if (!div_run_ff) begin
               state_in = ST_Z_RD;
            end
         end
         ST_Z_RD: begin
            state_in = ST_Z_CAP;
         end
         ST_Z_CAP: begin
            div_load   = 1'b1;
            div_num_ld = DIV_BITS'({z_mag, {FRAC_BITS{1'b0}}});
            div_den_ld = sd_ff;
            state_in   = ST_Z_DIV;
         end
         ST_Z_DIV: begin
            if (!div_run_ff) begin
               state_in = ST_Z_SQ;
            end
         end
         ST_Z_SQ: begin
            state_in = ST_Z_POW;
         end
         ST_Z_POW: begin
            state_in = ST_Z_ACC;
         end
         ST_Z_ACC: begin
            state_in = (idx_ff + CNT_BITS'(1) == n_ff) ? ST_KURT_GO : ST_Z_RD;
         end
         ST_KURT_GO: begin
            div_load   = 1'b1;
            div_num_ld = DIV_BITS'(z4sum_ff);
            div_den_ld = DEN_BITS'(n_ff);
            state_in   = ST_KURT_DIV;
         end
         ST_KURT_DIV: begin
            if (!div_run_ff) begin
               div_load   = 1'b1;
               div_num_ld = DIV_BITS'(zs3_mag);
               div_den_ld = DEN_BITS'(n_ff);
               state_in   = ST_SKEW_DIV;
            end
         end
         ST_SKEW_DIV: begin
            if (!div_run_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               emit_load = 1'b1;
               if (emit_idx_ff == FEAT_MAD) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               emit_load = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory read address follows the sweep in progress
   always_comb begin
      unique case (state_ff)
         ST_SEL_SCAN: rd_addr = j_ff[ADDR_BITS-1:0];
         default:     rd_addr = idx_ff[ADDR_BITS-1:0];
      endcase
   end

   // feature selection for the output register
   always_comb begin
      unique case (emit_idx_ff)
         FEAT_SD:       feat_val = sd_ff;
         FEAT_VAR:      feat_val = var_ff;
         FEAT_RMS:      feat_val = rms_ff;
         FEAT_MSQ:      feat_val = msq_ff;
         FEAT_PEARSON:  feat_val = pear_ff;
         FEAT_KURTOSIS: feat_val = kurt_ff;
         FEAT_SKEWNESS: feat_val = skew_ff;
         FEAT_MIN:      feat_val = VALUE_BITS'({min_ff, {FRAC_BITS{1'b0}}});
         FEAT_MAX:      feat_val = VALUE_BITS'({max_ff, {FRAC_BITS{1'b0}}});
         FEAT_MEAN:     feat_val = mean_ff;
         FEAT_MEDIAN:   feat_val = VALUE_BITS'({med_ff, {FRAC_BITS{1'b0}}});
         FEAT_MAD:      feat_val = VALUE_BITS'({mad_ff, {FRAC_BITS{1'b0}}});
         default:       feat_val = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         div_run_ff   <= 1'b0;
         sq_run_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_count_ff <= MIN_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         if (req_acc) begin
            cnt_ff <= req_data.window_end ? '0 : cnt_nx;
         end
         if (div_load) begin
            div_run_ff <= 1'b1;
         end else if (div_run_ff && (div_cnt_ff == 7'd1)) begin
            div_run_ff <= 1'b0;
         end
         if (sq_load) begin
            sq_run_ff <= 1'b1;
         end else if (sq_run_ff && (sq_cnt_ff == 6'd1)) begin
            sq_run_ff <= 1'b0;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            min_count_ff <= csr_wr_data;
         end
      end
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[cnt_ff[ADDR_BITS-1:0]] <= req_data.sample;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   // divider and root datapath
   always_ff @(posedge clock) begin
      if (div_load) begin
         div_num_ff <= div_num_ld;
         div_den_ff <= div_den_ld;
         div_rem_ff <= '0;
         div_q_ff   <= '0;
         div_cnt_ff <= 7'(DIV_BITS);
      end else if (div_run_ff) begin
         div_num_ff <= {div_num_ff[DIV_BITS-2:0], 1'b0};
         div_rem_ff <= div_rem_nx;
         div_q_ff   <= {div_q_ff[DIV_BITS-2:0], div_ge};
         div_cnt_ff <= div_cnt_ff - 7'd1;
      end
      if (sq_load) begin
         sq_rad_ff  <= sq_rad_ld;
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
         sq_cnt_ff  <= 6'(ROOT_BITS);
      end else if (sq_run_ff) begin
         sq_rad_ff  <= {sq_rad_ff[DIV_BITS-3:0], 2'b00};
         sq_rem_ff  <= sq_rem_nx;
         sq_root_ff <= {sq_root_ff[ROOT_BITS-2:0], sq_ge};
         sq_cnt_ff  <= sq_cnt_ff - 6'd1;
      end
   end

   // ---------------------------------------------------------------------------
   // window datapath
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      // sums and extremes restart with the first sample of a window
      if (store_wr) begin
         if (cnt_ff == '0) begin
            sum_ff   <= SUM_BITS'(req_data.sample);
            sumsq_ff <= SUMSQ_BITS'(req_data.sample) * SUMSQ_BITS'(req_data.sample);
            min_ff   <= req_data.sample;
            max_ff   <= req_data.sample;
         end else begin
            sum_ff   <= sum_ff + SUM_BITS'(req_data.sample);
            sumsq_ff <= sumsq_ff
                      + SUMSQ_BITS'(req_data.sample) * SUMSQ_BITS'(req_data.sample);
            if (req_data.sample < min_ff) begin
               min_ff <= req_data.sample;
            end
            if (req_data.sample > max_ff) begin
               max_ff <= req_data.sample;
            end
         end
      end
      if (req_acc && req_data.window_end) begin
         n_ff <= cnt_nx;
      end

      unique case (state_ff)
         ST_IDLE: begin
            emit_idx_ff <= FEAT_SD;
         end
         ST_PREP1: begin
            nm1_ff <= (2*CNT_BITS)'(n_ff) * (2*CNT_BITS)'(n_ff - CNT_BITS'(1));
            nq_ff  <= DEV_BITS'(n_ff) * DEV_BITS'(sumsq_ff);
            ss_ff  <= DEV_BITS'(sum_ff) * DEV_BITS'(sum_ff);
         end
         ST_SD_DIV: begin
            if (!div_run_ff) begin
               var_ff <= sat_q(div_q_ff >> FRAC_BITS);
            end
         end
         ST_SD_SQRT: begin
            if (!sq_run_ff) begin
               sd_ff <= VALUE_BITS'(sq_root_ff);
            end
         end
         ST_RMS_DIV: begin
            if (!div_run_ff) begin
               msq_ff <= sat_q(div_q_ff >> FRAC_BITS);
            end
         end
         ST_RMS_SQRT: begin
            if (!sq_run_ff) begin
               rms_ff <= VALUE_BITS'(sq_root_ff);
            end
         end
         ST_MEAN_DIV: begin
            if (!div_run_ff) begin
               mean_ff    <= div_q_ff[VALUE_BITS-1:0];
               idx_ff     <= '0;
               sel_mad_ff <= 1'b0;
            end
         end
         ST_SEL_CAP: begin
            // candidate for the wanted rank, then count how many lie below it
            cand_ff <= sel_val(rd_data_ff, med_ff, sel_mad_ff);
            j_ff    <= '0;
            lt_ff   <= '0;
            le_ff   <= '0;
            dv_ff   <= 1'b0;
         end
         ST_SEL_SCAN: begin
            if (j_ff != n_ff) begin
               j_ff <= j_ff + CNT_BITS'(1);
            end
            dv_ff <= (j_ff != n_ff);
            if (dv_ff) begin
               if (sel_val(rd_data_ff, med_ff, sel_mad_ff) < cand_ff) begin
                  lt_ff <= lt_ff + CNT_BITS'(1);
               end
               if (sel_val(rd_data_ff, med_ff, sel_mad_ff) <= cand_ff) begin
                  le_ff <= le_ff + CNT_BITS'(1);
               end
            end
            if ((j_ff == n_ff) && !dv_ff) begin
               if (!found) begin
                  idx_ff <= idx_ff + CNT_BITS'(1);
               end else if (!sel_mad_ff) begin
                  med_ff     <= cand_ff;
                  sel_mad_ff <= 1'b1;
                  idx_ff     <= '0;
               end else begin
                  mad_ff  <= cand_ff;
                  pneg_ff <= pear_diff[PD_BITS-1];
                  // constant window: the normalized moments are zero
                  if (sd_ff == '0) begin
                     pear_ff <= '0;
                     kurt_ff <= '0;
                     skew_ff <= '0;
                  end
               end
            end
         end
         ST_PEAR_DIV: begin
            if (!div_run_ff) begin
               pear_ff  <= pneg_ff ? VALUE_BITS'(0) - sat_q(div_q_ff) : sat_q(div_q_ff);
               z4sum_ff <= '0;
               zs3_ff   <= '0;
               idx_ff   <= '0;
            end
         end
         ST_Z_CAP: begin
            zneg_ff <= z_diff[PD_BITS-1];
         end
         ST_Z_DIV: begin
            if (!div_run_ff) begin
               az_ff <= (div_q_ff > DIV_BITS'(Z_LIM)) ? Z_LIM : div_q_ff[ZQ_BITS-1:0];
            end
         end
         ST_Z_SQ: begin
            z2_ff <= z2_prod[2*ZQ_BITS-1:FRAC_BITS];
         end
         ST_Z_POW: begin
            z4_ff <= z4_prod[2*Z2_BITS-1:FRAC_BITS];
            z3_ff <= z3_prod[Z2_BITS+ZQ_BITS-1:FRAC_BITS];
         end
         ST_Z_ACC: begin
            z4sum_ff <= z4sum_ff + Z4SUM_BITS'(z4_ff);
            if (zneg_ff) begin
               zs3_ff <= zs3_ff - $signed(Z3SUM_BITS'(z3_ff));
            end else begin
               zs3_ff <= zs3_ff + $signed(Z3SUM_BITS'(z3_ff));
            end
            idx_ff <= idx_ff + CNT_BITS'(1);
         end
         ST_KURT_DIV: begin
            if (!div_run_ff) begin
               kurt_ff <= sat_q(div_q_ff);
            end
         end
         ST_SKEW_DIV: begin
            // truncation toward zero: divide the magnitude, restore the sign
            if (!div_run_ff) begin
               skew_ff <= zs3_ff[Z3SUM_BITS-1] ? VALUE_BITS'(0) - skew_mag : skew_mag;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               emit_idx_ff <= emit_idx_ff + INDEX_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (emit_load) begin
         if (state_ff == ST_ERR) begin
            rsp_data_ff.feature_index <= FEAT_SD;
            rsp_data_ff.feature_value <= '0;
            rsp_data_ff.too_few       <= 1'b1;
            rsp_data_ff.final_result  <= 1'b1;
         end else begin
            rsp_data_ff.feature_index <= emit_idx_ff;
            rsp_data_ff.feature_value <= $signed(feat_val);
            rsp_data_ff.too_few       <= 1'b0;
            rsp_data_ff.final_result  <= (emit_idx_ff == FEAT_MAD);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/wsf_checker.sv =====
// port-level checks of the window statistics block and their binding
`timescale 1ns / 1ps

module wsf_checker
   import wsf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input req_type                req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rsp_type                rsp_data,
   input logic                   csr_wr_en,
   input logic [MINCNT_BITS-1:0] csr_wr_data
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // a short window gives one zero item that ends the window
   a_err_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.too_few |->
         rsp_data.final_result && (rsp_data.feature_value == '0)
         && (rsp_data.feature_index == FEAT_SD))
      else $error("malformed short-window item");

   // feature items end exactly on the last feature code
   a_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.too_few |->
         (rsp_data.final_result == (rsp_data.feature_index == FEAT_MAD)))
      else $error("final flag out of place");

   // closing a window stops intake for the feature pass
   a_close_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.window_end |=> req_stall)
      else $error("input taken right after window close");

endmodule

bind window_statistics_features wsf_checker u_wsf_checker (.*);
